// ===== rtl/assert_macros.svh =====
// Shared assertion helpers; each expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Delayed implication.
`define ASSERT_LATER(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
    else $error("two-cycle check failed");

`endif

// ===== rtl/frl_pkg.sv =====
`default_nettype none

package frl_pkg;

  localparam int unsigned KeyInW   = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgDataW-1:0] MaxRequestsRst   = 16'd100;
  localparam logic [CfgDataW-1:0] WindowSecondsRst = 16'd60;
  localparam logic [CountW-1:0]   CountOne         = 16'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_REQUESTS   = 2'd0,
    CFG_WINDOW_SECONDS = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic allowed;
    logic table_full;
  } frl_result_t;

endpackage

`default_nettype wire

// ===== rtl/frl_if.sv =====
`default_nettype none

interface frl_req_if;
  logic                        valid;
  logic                        ready;
  logic [frl_pkg::KeyInW-1:0]  client_key;
  logic [frl_pkg::TimeW-1:0]   now_seconds;

  modport source (output valid, client_key, now_seconds, input ready);
  modport sink   (input valid, client_key, now_seconds, output ready);
endinterface

interface frl_resp_if;
  logic valid;
  logic ready;
  logic allowed;
  logic table_full;

  modport source (output valid, allowed, table_full, input ready);
  modport sink   (input valid, allowed, table_full, output ready);
endinterface

interface frl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [frl_pkg::CfgIdxW-1:0]   index;
  logic [frl_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/frl_table.sv =====
`default_nettype none

module frl_table #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned KEY_WIDTH     = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            upd_i,
  input  wire logic [KEY_WIDTH-1:0]            key_i,
  input  wire logic [frl_pkg::TimeW-1:0]       now_i,
  input  wire logic [frl_pkg::CfgDataW-1:0]    max_requests_i,
  input  wire logic [frl_pkg::CfgDataW-1:0]    window_seconds_i,
  output frl_pkg::frl_result_t                 result_o
);

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [KEY_WIDTH-1:0]     key_q   [TABLE_ENTRIES];
  logic [frl_pkg::CountW-1:0] count_q [TABLE_ENTRIES];
  logic [frl_pkg::TimeW-1:0]  start_q [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] hit;
  logic [TABLE_ENTRIES-1:0] expired;
  logic [TABLE_ENTRIES-1:0] spare;
  logic [TABLE_ENTRIES-1:0] spare_first;
  logic [TABLE_ENTRIES-1:0] claim;
  logic [TABLE_ENTRIES-1:0] deny;
  logic                     any_hit;

  // Per-entry compare lanes.
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit[i]     = valid_q[i] && (key_q[i] == key_i);
      expired[i] = (now_i - start_q[i]) > {16'd0, window_seconds_i};
      spare[i]   = !hit[i] && (!valid_q[i] || expired[i]);
      deny[i]    = hit[i] && !expired[i] && (count_q[i] >= max_requests_i);
    end
  end

  assign any_hit     = |hit;
  // Isolate the lowest free or expired entry.
  assign spare_first = spare & (~spare + {{(TABLE_ENTRIES-1){1'b0}}, 1'b1});
  assign claim       = any_hit ? '0 : spare_first;

  assign result_o.allowed    = ~|deny;
  assign result_o.table_full = !any_hit && (~|spare);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (upd_i) begin
      valid_q <= valid_q | claim;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (upd_i) begin
        if (claim[i]) begin
          key_q[i]   <= key_i;
          count_q[i] <= frl_pkg::CountOne;
          start_q[i] <= now_i;
        end else if (hit[i]) begin
          if (expired[i]) begin
            count_q[i] <= frl_pkg::CountOne;
            start_q[i] <= now_i;
          end else if (!deny[i]) begin
            count_q[i] <= count_q[i] + frl_pkg::CountOne;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fixed_window_rate_limiter.sv =====
// Channel   | Dir | Payload                          | Accept
// req_i     | in  | client_key[31:0], now_seconds    | valid && ready
// resp_o    | out | allowed, table_full               | valid && ready
// cfg_i     | in  | index[1:0], data[15:0]           | valid && ready (always ready)
//
// One request per cycle while no stalled response holds the input stage; each request
// passes the input stage, then the response register. Its table lookup and update occur
// together as it moves into the response register, across all entries in parallel.
// Reset clears the valid marks of all entries at once; no clearing pass.
// A stalled response holds the input stage; ready drops only while both are full.
`default_nettype none

module fixed_window_rate_limiter #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned KEY_WIDTH     = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  frl_req_if.sink     req_i,
  frl_resp_if.source  resp_o,
  frl_cfg_if.sink     cfg_i
);

  localparam int unsigned KeyUseW =
    (KEY_WIDTH < frl_pkg::KeyInW) ? KEY_WIDTH : frl_pkg::KeyInW;

  logic                           in_valid_q;
  logic [KEY_WIDTH-1:0]           key_q, key_d;
  logic [frl_pkg::TimeW-1:0]      now_q;
  logic                           out_valid_q;
  frl_pkg::frl_result_t           out_q;
  frl_pkg::frl_result_t           lookup;
  logic [frl_pkg::CfgDataW-1:0]   max_requests_q;
  logic [frl_pkg::CfgDataW-1:0]   window_seconds_q;
  logic                           advance;
  logic                           req_take;

  assign advance  = in_valid_q && (!out_valid_q || resp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign req_take = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // Keep only the compared key bits.
  always_comb begin
    key_d = '0;
    key_d[KeyUseW-1:0] = req_i.client_key[KeyUseW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (resp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      key_q <= key_d;
      now_q <= req_i.now_seconds;
    end
    if (advance) begin
      out_q <= lookup;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_requests_q   <= frl_pkg::MaxRequestsRst;
      window_seconds_q <= frl_pkg::WindowSecondsRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        frl_pkg::CFG_MAX_REQUESTS:   max_requests_q   <= cfg_i.data;
        frl_pkg::CFG_WINDOW_SECONDS: window_seconds_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  frl_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_WIDTH     (KEY_WIDTH)
  ) u_table (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .upd_i            (advance),
    .key_i            (key_q),
    .now_i            (now_q),
    .max_requests_i   (max_requests_q),
    .window_seconds_i (window_seconds_q),
    .result_o         (lookup)
  );

  assign resp_o.valid      = out_valid_q;
  assign resp_o.allowed    = out_q.allowed;
  assign resp_o.table_full = out_q.table_full;

endmodule

`default_nettype wire

// ===== rtl/frl_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module frl_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid_i,
  input wire logic req_ready_i,
  input wire logic resp_valid_i,
  input wire logic resp_ready_i,
  input wire logic allowed_i,
  input wire logic table_full_i
);

  `ASSERT_NEXT(a_resp_hold, clk_i, rst_ni, resp_valid_i && !resp_ready_i, resp_valid_i && $stable(allowed_i) && $stable(table_full_i))
  `ASSERT_IMPLY(a_full_allows, clk_i, rst_ni, resp_valid_i && table_full_i, allowed_i)
  `ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, !req_ready_i, resp_valid_i && !resp_ready_i)
  `ASSERT_LATER(a_req_resp, clk_i, rst_ni, req_valid_i && req_ready_i, resp_valid_i)

endmodule

bind fixed_window_rate_limiter frl_checker u_frl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .resp_valid_i (resp_o.valid),
  .resp_ready_i (resp_o.ready),
  .allowed_i    (resp_o.allowed),
  .table_full_i (resp_o.table_full)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Entries    = 64;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 126;

  // Indexes past the two registers; writes to them must change nothing.
  localparam logic [frl_pkg::CfgIdxW-1:0] CfgIdxSpareA = 2'd2;
  localparam logic [frl_pkg::CfgIdxW-1:0] CfgIdxSpareB = 2'd3;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  frl_req_if  req_if ();
  frl_resp_if resp_if ();
  frl_cfg_if  cfg_if ();

  fixed_window_rate_limiter DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .resp_o (resp_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk = ~clk;

  // Limiter state as predicted from the accepted requests.
  logic                         track_valid [Entries];
  logic [frl_pkg::KeyInW-1:0]   track_key   [Entries];
  logic [frl_pkg::CountW-1:0]   track_count [Entries];
  logic [frl_pkg::TimeW-1:0]    track_start [Entries];
  logic [frl_pkg::CfgDataW-1:0] limit_max;
  logic [frl_pkg::CfgDataW-1:0] limit_window;

  frl_pkg::frl_result_t expected_verdicts[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  function automatic logic window_over(int idx, logic [frl_pkg::TimeW-1:0] now);
    logic [frl_pkg::TimeW-1:0] elapsed;
    elapsed = now - track_start[idx];
    return elapsed > {{(frl_pkg::TimeW-frl_pkg::CfgDataW){1'b0}}, limit_window};
  endfunction

  function automatic frl_pkg::frl_result_t rate_verdict(logic [frl_pkg::KeyInW-1:0] key,
                                                        logic [frl_pkg::TimeW-1:0] now);
    int hit;
    int spare;
    frl_pkg::frl_result_t verdict;
    hit = -1;
    spare = -1;
    verdict.allowed = 1'b1;
    verdict.table_full = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      if (track_valid[i] && track_key[i] == key) begin
        if (hit < 0) hit = i;
      end else if (!track_valid[i] || window_over(i, now)) begin
        if (spare < 0) spare = i;
      end
    end
    if (hit >= 0) begin
      if (window_over(hit, now)) begin
        track_count[hit] = frl_pkg::CountOne;
        track_start[hit] = now;
      end else if (track_count[hit] >= limit_max) begin
        verdict.allowed = 1'b0;
      end else begin
        track_count[hit] = track_count[hit] + frl_pkg::CountOne;
      end
    end else if (spare >= 0) begin
      track_valid[spare] = 1'b1;
      track_key[spare]   = key;
      track_count[spare] = frl_pkg::CountOne;
      track_start[spare] = now;
    end else begin
      verdict.table_full = 1'b1;
    end
    return verdict;
  endfunction

  // Check responses, track register writes, predict each accepted request.
  always @(posedge clk) begin
    frl_pkg::frl_result_t want;
    if (!rst_n) begin
      limit_max    <= frl_pkg::MaxRequestsRst;
      limit_window <= frl_pkg::WindowSecondsRst;
      for (int i = 0; i < Entries; i++) track_valid[i] <= 1'b0;
    end else begin
      if (resp_if.valid === 1'b1 && resp_if.ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected response allowed=%b table_full=%b", $time,
                   resp_if.allowed, resp_if.table_full);
          mismatch_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (resp_if.allowed !== want.allowed) begin
            $display("%0t: allowed expected %b actual %b", $time, want.allowed,
                     resp_if.allowed);
            mismatch_count++;
          end
          if (resp_if.table_full !== want.table_full) begin
            $display("%0t: table_full expected %b actual %b", $time,
                     want.table_full, resp_if.table_full);
            mismatch_count++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          frl_pkg::CFG_MAX_REQUESTS:   limit_max = cfg_if.data;
          frl_pkg::CFG_WINDOW_SECONDS: limit_window = cfg_if.data;
          default: ;
        endcase
      end
      if (req_if.valid && req_if.ready)
        expected_verdicts.push_back(rate_verdict(req_if.client_key, req_if.now_seconds));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout with %0d responses outstanding", $time,
               expected_verdicts.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    resp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      resp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic set_idling(idle_mode_e mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 49 : (mode == IDLE_BOTH) ? 34 : 0;
    stall_pct     = (mode == IDLE_RECEIVER) ? 49 : (mode == IDLE_BOTH) ? 34 : 0;
  endtask

  // Leave valid high on return so back-to-back requests need no second assignment.
  task automatic send_request(logic [frl_pkg::KeyInW-1:0] key,
                              logic [frl_pkg::TimeW-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.client_key  <= key;
    req_if.now_seconds <= now;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Hold the sender until every response is back.
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (expected_verdicts.size() != 0);
  endtask

  task automatic write_register(logic [frl_pkg::CfgIdxW-1:0] idx,
                                logic [frl_pkg::CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(logic [frl_pkg::CfgDataW-1:0] max_req,
                            logic [frl_pkg::CfgDataW-1:0] window);
    drain_responses();
    write_register(frl_pkg::CFG_MAX_REQUESTS, max_req);
    write_register(frl_pkg::CFG_WINDOW_SECONDS, window);
  endtask

  // Reset values; window edge exactly at the limit; time running backwards.
  task automatic test_defaults();
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h0000_0000, 32'd60);
    send_request(32'h0000_0000, 32'd61);
    send_request(32'h0000_0000, 32'd5);
    send_request(32'hFFFF_FFFF, 32'd59);
  endtask

  // Zero and full-scale registers, plus writes to the unused indexes.
  task automatic test_register_extremes();
    set_limits(16'h0000, 16'h0000);
    send_request(32'h1234_5678, 32'd1000);
    send_request(32'h1234_5678, 32'd1000);
    send_request(32'h1234_5678, 32'd1001);
    set_limits(16'hFFFF, 16'hFFFF);
    send_request(32'h1234_5678, 32'd2000);
    send_request(32'h1234_5678, 32'd2000 + 32'd65536);
    drain_responses();
    write_register(CfgIdxSpareA, 16'hFFFF);
    write_register(CfgIdxSpareB, 16'h0000);
    send_request(32'h1234_5678, 32'd2001 + 32'd65536);
  endtask

  // Lower the limit below a live count, then raise it again.
  task automatic test_lowered_limit();
    set_limits(16'd3, 16'd100);
    repeat (4) send_request(32'hA5A5_0F0F, 32'd5000);
    set_limits(16'd1, 16'd100);
    send_request(32'hA5A5_0F0F, 32'd5001);
    set_limits(16'd5, 16'd100);
    send_request(32'hA5A5_0F0F, 32'd5002);
  endtask

  // Fill every entry, overflow it, then let the windows lapse and reuse them.
  task automatic test_table_full();
    logic [frl_pkg::KeyInW-1:0] base;
    logic [frl_pkg::TimeW-1:0]  now;
    base = $urandom;
    now  = 32'h8000_0000;
    set_limits(16'hFFFF, 16'hFFFF);
    for (int i = 0; i < Entries + 6; i++) send_request(base + i * 32'h0101_0101, now);
    send_request(base, now + 32'd10);
    now = now + 32'd65536;
    send_request(32'hDEAD_BEEF, now);
    send_request(base + 32'h0101_0101, now + 32'd1);
    send_request(base + 32'h0101_0101, now + 32'd1);
  endtask

  task automatic test_random_traffic();
    logic [frl_pkg::KeyInW-1:0]   client_pool[$];
    logic [frl_pkg::TimeW-1:0]    now;
    logic [frl_pkg::CfgDataW-1:0] max_req;
    logic [frl_pkg::CfgDataW-1:0] window;
    int unsigned                  pool_size;
    int unsigned                  pick;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(3))
        0:       max_req = 16'h0000;
        1:       max_req = 16'hFFFF;
        2:       max_req = 16'($urandom_range(65535));
        default: max_req = 16'($urandom_range(1, 6));
      endcase
      case ($urandom_range(3))
        0:       window = 16'h0000;
        1:       window = 16'hFFFF;
        2:       window = 16'($urandom_range(65535));
        default: window = 16'($urandom_range(1, 8));
      endcase
      set_limits(max_req, window);
      set_idling(idle_mode_e'(phase % 4));
      pool_size = ($urandom_range(3) == 0) ? $urandom_range(65, 100) : $urandom_range(1, 40);
      client_pool.delete();
      repeat (pool_size) client_pool.push_back($urandom);
      now = $urandom;
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(99);
        if (pick < 3) now = now - $urandom_range(1, 1000);
        else if (pick < 6) now = now + $urandom_range(65536, 32'h7FFF_FFFF);
        else if (pick < 60) now = now + $urandom_range(0, 3);
        if ($urandom_range(9) == 0)
          send_request($urandom, now);
        else
          send_request(client_pool[$urandom_range(pool_size - 1)], now);
      end
    end
    set_idling(IDLE_NONE);
  endtask

  initial begin
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.client_key = '0;
    req_if.now_seconds = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = frl_pkg::CFG_MAX_REQUESTS;
    cfg_if.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_register_extremes();
    test_lowered_limit();
    test_table_full();
    test_random_traffic();

    drain_responses();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
